FILE: hw/rtl/segment_plane_intersection_macros.svh
// Assertion macros shared by the block. They assume a clock named clk and a
// synchronous active-high reset named rst in the module that uses them.
`ifndef SEGMENT_PLANE_INTERSECTION_MACROS_SVH
`define SEGMENT_PLANE_INTERSECTION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/spi_pkg.sv
package spi_pkg;

  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_X  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_Y  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_Z  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_X = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_Y = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_Z = 3'd5;

  typedef enum logic [1:0] {
    OUTCOME_MISS     = 2'd0,
    OUTCOME_HIT      = 2'd1,
    OUTCOME_PARALLEL = 2'd2
  } outcome_t;

endpackage

FILE: hw/rtl/spi_div.sv
// Pipelined restoring divider: one quotient bit per stage, numerator below
// or equal to the denominator on entry. Sideband data rides along.
module spi_div #(
  parameter int W  = 35,
  parameter int F  = 16,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic [SW-1:0] side_in,
  output logic          vout,
  output logic [F-1:0]  quo,
  output logic [SW-1:0] side_out
);

  logic [W-1:0]  r_q  [1:F];
  logic [W-1:0]  dn_q [1:F];
  logic [F-1:0]  qs_q [1:F];
  logic [SW-1:0] sd_q [1:F];
  logic          v_q  [1:F];

  for (genvar k = 0; k < F; k++) begin : g_stage
    logic [W-1:0]  r_cur;
    logic [W-1:0]  dn_cur;
    logic [F-1:0]  qs_cur;
    logic [SW-1:0] sd_cur;
    logic          v_cur;
    logic [W:0]    t;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_cur  = num;
      assign dn_cur = den;
      assign qs_cur = '0;
      assign sd_cur = side_in;
      assign v_cur  = vin;
    end else begin : g_rest
      assign r_cur  = r_q[k];
      assign dn_cur = dn_q[k];
      assign qs_cur = qs_q[k];
      assign sd_cur = sd_q[k];
      assign v_cur  = v_q[k];
    end

    assign t  = {r_cur, 1'b0};
    assign ge = (t >= {1'b0, dn_cur});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k+1]  <= ge ? W'(t - {1'b0, dn_cur}) : W'(t);
        dn_q[k+1] <= dn_cur;
        qs_q[k+1] <= {qs_cur[F-2:0], ge};
        sd_q[k+1] <= sd_cur;
      end
    end
  end

  assign vout     = v_q[F];
  assign quo      = qs_q[F];
  assign side_out = sd_q[F];

endmodule

FILE: hw/rtl/segment_plane_intersection.sv
// Throughput: one segment per cycle while the output is not stalled; the
// divider spends one stage per fraction bit.
// A stalled output holds the whole pipeline in place; nothing is dropped.
// Reset clears all valid bits and sets the plane to point 0, normal (0, 0, 1).
module segment_plane_intersection #(
  parameter int COORD_BITS = spi_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = spi_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [spi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        start_x,
  input  logic signed [COORD_BITS-1:0]        start_y,
  input  logic signed [COORD_BITS-1:0]        start_z,
  input  logic signed [COORD_BITS-1:0]        end_x,
  input  logic signed [COORD_BITS-1:0]        end_y,
  input  logic signed [COORD_BITS-1:0]        end_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          outcome,
  output logic [FRAC_BITS:0]                  fraction,
  output logic signed [COORD_BITS-1:0]        hit_x,
  output logic signed [COORD_BITS-1:0]        hit_y,
  output logic signed [COORD_BITS-1:0]        hit_z
);
  import spi_pkg::*;
  `include "segment_plane_intersection_macros.svh"

  localparam int C  = COORD_BITS;
  localparam int CW = C + 1;
  localparam int PW = 2 * C + 1;
  localparam int W  = 2 * C + 3;
  localparam int MW = CW + FRAC_BITS + 2;
  localparam int SW = 2 + 1 + 3 * C + 3 * CW;

  logic signed [C-1:0] plane [0:2];
  logic signed [C-1:0] nrm   [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      plane[0] <= '0;
      plane[1] <= '0;
      plane[2] <= '0;
      nrm[0]   <= '0;
      nrm[1]   <= '0;
      nrm[2]   <= C'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PLANE_X:  plane[0] <= cfg_data;
        REG_PLANE_Y:  plane[1] <= cfg_data;
        REG_PLANE_Z:  plane[2] <= cfg_data;
        REG_NORMAL_X: nrm[0]   <= cfg_data;
        REG_NORMAL_Y: nrm[1]   <= cfg_data;
        REG_NORMAL_Z: nrm[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic signed [C-1:0] st [0:2];
  logic signed [C-1:0] ed [0:2];
  assign st[0] = start_x;
  assign st[1] = start_y;
  assign st[2] = start_z;
  assign ed[0] = end_x;
  assign ed[1] = end_y;
  assign ed[2] = end_z;

  // Stage 1: direction and plane offset.
  logic                 v1;
  logic signed [C-1:0]  s1_s  [0:2];
  logic signed [CW-1:0] s1_d  [0:2];
  logic signed [CW-1:0] s1_pm [0:2];
  // Stage 2: products with the normal.
  logic                 v2;
  logic signed [C-1:0]  s2_s  [0:2];
  logic signed [CW-1:0] s2_d  [0:2];
  logic signed [PW-1:0] s2_pd [0:2];
  logic signed [PW-1:0] s2_pp [0:2];
  // Stage 3: dot products.
  logic                 v3;
  logic signed [C-1:0]  s3_s  [0:2];
  logic signed [CW-1:0] s3_d  [0:2];
  logic signed [W-1:0]  s3_den;
  logic signed [W-1:0]  s3_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_s[i]  <= st[i];
        s1_d[i]  <= CW'(ed[i]) - CW'(st[i]);
        s1_pm[i] <= CW'(plane[i]) - CW'(st[i]);
        s2_s[i]  <= s1_s[i];
        s2_d[i]  <= s1_d[i];
        s2_pd[i] <= PW'(s1_d[i]) * PW'(nrm[i]);
        s2_pp[i] <= PW'(s1_pm[i]) * PW'(nrm[i]);
        s3_s[i]  <= s2_s[i];
        s3_d[i]  <= s2_d[i];
      end
      s3_den <= W'(s2_pd[0]) + W'(s2_pd[1]) + W'(s2_pd[2]);
      s3_num <= W'(s2_pp[0]) + W'(s2_pp[1]) + W'(s2_pp[2]);
    end
  end

  // Stage 4: sign normalization and range test, feeding the divider.
  logic                den_neg;
  logic signed [W-1:0] aden;
  logic signed [W-1:0] anum;
  outcome_t            cls;

  assign den_neg = s3_den[W-1];
  assign aden    = den_neg ? -s3_den : s3_den;
  assign anum    = den_neg ? -s3_num : s3_num;

  always_comb begin
    if (s3_den == '0) begin
      cls = OUTCOME_PARALLEL;
    end else if (anum[W-1] || ($unsigned(aden) < $unsigned(anum))) begin
      cls = OUTCOME_MISS;
    end else begin
      cls = OUTCOME_HIT;
    end
  end

  logic                 v4;
  logic [W-1:0]         s4_num;
  logic [W-1:0]         s4_den;
  logic [SW-1:0]        s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_num  <= (cls == OUTCOME_HIT) ? $unsigned(anum) : '0;
      s4_den  <= $unsigned(aden);
      s4_side <= {cls, (anum == aden), s3_s[0], s3_s[1], s3_s[2],
                  s3_d[0], s3_d[1], s3_d[2]};
    end
  end

  logic                 vd;
  logic [FRAC_BITS-1:0] quo;
  logic [SW-1:0]        dside;

  spi_div #(
    .W  (W),
    .F  (FRAC_BITS),
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v4),
    .num      (s4_num),
    .den      (s4_den),
    .side_in  (s4_side),
    .vout     (vd),
    .quo      (quo),
    .side_out (dside)
  );

  outcome_t             d_cls;
  logic                 d_eq;
  logic signed [C-1:0]  d_s [0:2];
  logic signed [CW-1:0] d_d [0:2];
  logic [FRAC_BITS:0]   d_q;

  assign d_cls  = outcome_t'(dside[SW-1 -: 2]);
  assign d_eq   = dside[SW-3];
  assign d_s[0] = dside[3*CW + 3*C - 1 -: C];
  assign d_s[1] = dside[3*CW + 2*C - 1 -: C];
  assign d_s[2] = dside[3*CW + C - 1 -: C];
  assign d_d[0] = dside[3*CW - 1 -: CW];
  assign d_d[1] = dside[2*CW - 1 -: CW];
  assign d_d[2] = dside[CW - 1 -: CW];
  // A numerator equal to the denominator means a fraction of exactly one.
  assign d_q    = d_eq ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, quo};

  // Stage 5: scale the direction by the fraction.
  logic                 v5;
  outcome_t             s5_cls;
  logic [FRAC_BITS:0]   s5_q;
  logic signed [C-1:0]  s5_s [0:2];
  logic signed [MW-1:0] s5_m [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5        <= vd;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_cls <= d_cls;
      s5_q   <= d_q;
      for (int i = 0; i < 3; i++) begin
        s5_s[i] <= d_s[i];
        s5_m[i] <= MW'(d_d[i]) * MW'($signed({1'b0, d_q}));
      end
    end
  end

  // Stage 6: arithmetic shift gives the floor of the scaled offset.
  logic signed [C-1:0] hp [0:2];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hp[i] = s5_s[i] + C'(s5_m[i] >>> FRAC_BITS);
    end
  end

  logic hit5;
  assign hit5 = (s5_cls == OUTCOME_HIT);

  always_ff @(posedge clk) begin
    if (en) begin
      outcome  <= s5_cls;
      fraction <= hit5 ? s5_q : '0;
      hit_x    <= hit5 ? hp[0] : '0;
      hit_y    <= hit5 ? hp[1] : '0;
      hit_z    <= hit5 ? hp[2] : '0;
    end
  end

  `SPI_ASSERT_SAME(a_zero_unless_hit, out_valid && outcome != OUTCOME_HIT,
    fraction == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0)
  `SPI_ASSERT_SAME(a_frac_range, out_valid && outcome == OUTCOME_HIT,
    fraction <= {1'b1, {FRAC_BITS{1'b0}}})
  `SPI_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v1)

endmodule
